// ===== src/rwsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rwsp_pkg: shared constants for the risk-weighted shortest path planner
// Field widths, request and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
package rwsp_pkg;

  localparam int MAX_NODES_DEF  = 64;
  localparam int COORD_BITS_DEF = 10;

  localparam int NODE_W     = 6;
  localparam int CNT_W      = 7;
  localparam int COORD_W    = 10;
  localparam int OCC_W      = 10;
  localparam int ROW_W      = 64;
  localparam int COST_W     = 32;
  localparam int LEN_W      = 25;
  localparam int RW_W       = 12;
  localparam int RISK_W     = 18;
  localparam int BCNT_W     = 8;
  localparam int DIV_W      = 22;
  localparam int MA_W       = 18;
  localparam int MB_W       = 16;
  localparam int MP_W       = 34;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 72;

  localparam logic [1:0] REQ_NODE = 2'd0;
  localparam logic [1:0] REQ_ROW  = 2'd1;
  localparam logic [1:0] REQ_PLAN = 2'd2;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_SAME    = 2'd1;
  localparam logic [1:0] ST_UNREACH = 2'd2;

  localparam logic [COST_W-1:0] COST_MAX = '1;
  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
  localparam logic [RW_W-1:0]   RW_RESET = 12'd256;

endpackage

// ===== src/rwsp_isqrt.sv =====
// ----------------------------------------------------------------------------
// rwsp_isqrt: iterative integer square root
// Resolves two operand bits per cycle; busy_o stays high until the root holds.
// ----------------------------------------------------------------------------
module rwsp_isqrt #(
  parameter int VW = 38,
  parameter int HW = 19
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [VW-1:0] op_i,
  output logic          busy_o,
  output logic [HW-1:0] root_o
);

  logic [VW-1:0] v_q, r_q, bit_q;
  logic [VW:0]   trial;

  assign trial  = {1'b0, r_q} + {1'b0, bit_q};
  assign busy_o = (bit_q != '0);
  assign root_o = r_q[HW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (start_i) begin
      bit_q <= VW'(1) << (VW - 2);
    end else if (busy_o) begin
      bit_q <= bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= op_i;
      r_q <= '0;
    end else if (busy_o) begin
      if ({1'b0, v_q} >= trial) begin
        v_q <= v_q - trial[VW-1:0];
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
    end
  end

endmodule

// ===== src/risk_weighted_shortest_path.sv =====
// ----------------------------------------------------------------------------
// risk_weighted_shortest_path: Dijkstra planner over a small dense graph
// Loads nodes and adjacency rows, plans a risk-weighted path, streams it out.
// ----------------------------------------------------------------------------
// Load words are accepted only while the planner is idle. A plan word is worked
// by one sequencer that shares a multiplier, a restoring divider and an
// iterative square root: each minimum search scans the cost memory, and each
// relaxed edge sums its risk over the occupancy memory before the divide and
// the distance root. Each path hop reads node coordinates and takes a
// distance root, and each result word is read from the path memory before it
// is loaded into the output register. The input is not ready while a plan
// runs. Results leave goal first.
module risk_weighted_shortest_path #(
  parameter int MAX_NODES  = rwsp_pkg::MAX_NODES_DEF,
  parameter int COORD_BITS = rwsp_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  // node_index, coord_x, coord_y, occupancy, edge_row, start_node, goal_node,
  // node_count
  input  logic [rwsp_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  // req_type
  input  logic [1:0]                       s_tuser_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  // path_node, next_node, path_cost, path_length
  output logic [rwsp_pkg::OUT_TDATA_W-1:0] m_tdata_o,
  // status
  output logic [1:0]                       m_tuser_o,
  output logic                             m_tlast_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int NODES = (MAX_NODES < 64) ? MAX_NODES : 64;
  localparam int IW    = $clog2(NODES);
  localparam int CB    = COORD_BITS;
  localparam int VW    = 2 * CB + 18;
  localparam int HW    = CB + 9;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_INIT     = 5'd1;
  localparam logic [4:0] S_SINGLE   = 5'd2;
  localparam logic [4:0] S_SEL_RD   = 5'd3;
  localparam logic [4:0] S_SEL_CMP  = 5'd4;
  localparam logic [4:0] S_SEL_END  = 5'd5;
  localparam logic [4:0] S_ROWT_RD  = 5'd6;
  localparam logic [4:0] S_ROWT_LD  = 5'd7;
  localparam logic [4:0] S_REL_CHK  = 5'd8;
  localparam logic [4:0] S_REL_RD   = 5'd9;
  localparam logic [4:0] S_REL_LD   = 5'd10;
  localparam logic [4:0] S_RISK_RD  = 5'd11;
  localparam logic [4:0] S_RISK_ACC = 5'd12;
  localparam logic [4:0] S_MUL      = 5'd13;
  localparam logic [4:0] S_DIV      = 5'd14;
  localparam logic [4:0] S_DX       = 5'd15;
  localparam logic [4:0] S_DY       = 5'd16;
  localparam logic [4:0] S_SQ_GO    = 5'd17;
  localparam logic [4:0] S_SQ       = 5'd18;
  localparam logic [4:0] S_REL_BRD  = 5'd19;
  localparam logic [4:0] S_REL_UPD  = 5'd20;
  localparam logic [4:0] S_WALK_CHK = 5'd21;
  localparam logic [4:0] S_WALK_RD  = 5'd22;
  localparam logic [4:0] S_WALK_LD  = 5'd23;
  localparam logic [4:0] S_WALK_LD2 = 5'd24;
  localparam logic [4:0] S_EM_RD    = 5'd25;
  localparam logic [4:0] S_EM_OUT   = 5'd26;

  // Input fields.
  logic [rwsp_pkg::NODE_W-1:0]  in_idx, in_start, in_goal;
  logic [rwsp_pkg::COORD_W-1:0] in_x, in_y;
  logic [rwsp_pkg::OCC_W-1:0]   in_occ;
  logic [rwsp_pkg::ROW_W-1:0]   in_row;
  logic [rwsp_pkg::CNT_W-1:0]   in_cnt, in_cnt_lim;
  logic [15:0]                  in_x16, in_y16;

  assign in_idx   = s_tdata_i[5:0];
  assign in_x     = s_tdata_i[15:6];
  assign in_y     = s_tdata_i[25:16];
  assign in_occ   = s_tdata_i[35:26];
  assign in_row   = s_tdata_i[99:36];
  assign in_start = s_tdata_i[105:100];
  assign in_goal  = s_tdata_i[111:106];
  assign in_cnt   = s_tdata_i[118:112];
  assign in_x16   = 16'(in_x);
  assign in_y16   = 16'(in_y);
  assign in_cnt_lim = (in_cnt > rwsp_pkg::CNT_W'(NODES)) ? rwsp_pkg::CNT_W'(NODES) : in_cnt;

  logic [4:0] state_q;
  logic       in_acc, idx_ok, o_free, o_load;

  assign s_tready_o = (state_q == S_IDLE);
  assign in_acc     = s_tvalid_i && s_tready_o;
  assign idx_ok     = (rwsp_pkg::CNT_W'(in_idx) < rwsp_pkg::CNT_W'(NODES));

  // Configuration.
  logic [rwsp_pkg::RW_W-1:0] rw_q;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(rw_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rw_q <= rwsp_pkg::RW_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      rw_q <= pwdata[rwsp_pkg::RW_W-1:0];
    end
  end

  // Plan registers.
  logic [rwsp_pkg::NODE_W-1:0] s_q, g_q, t_q, y_q, p_q, next_q, r_node_q;
  logic [rwsp_pkg::CNT_W-1:0]  n_q, k_q, j_q, i_q, cnt_q;
  logic [1:0]                  r_status_q;
  logic                        found_q, walk_q;
  logic [rwsp_pkg::COST_W-1:0] tcost_q;
  logic [rwsp_pkg::LEN_W-1:0]  len_q;
  logic [NODES-1:0]            settled_q, reached_q;
  logic [rwsp_pkg::ROW_W-1:0]  row_t_q, row_j_q;
  logic [CB-1:0]               ax_q, ay_q, bx_q, by_q;
  logic [rwsp_pkg::OCC_W-1:0]  occ_t_q;
  logic [rwsp_pkg::RISK_W-1:0] risk_q;
  logic [rwsp_pkg::BCNT_W-1:0] b_q;
  logic [rwsp_pkg::DIV_W-1:0]  quo_q;
  logic [rwsp_pkg::BCNT_W-1:0] rem_q;
  logic [4:0]                  dcnt_q;
  logic [2*CB-1:0]             dxx_q, dyy_q;
  logic [HW-1:0]               hop_q;

  // Memories.
  logic [CB-1:0]                nx_mem [NODES];
  logic [CB-1:0]                ny_mem [NODES];
  logic [rwsp_pkg::OCC_W-1:0]   no_mem [NODES];
  logic [rwsp_pkg::ROW_W-1:0]   adj_mem [NODES];
  logic [rwsp_pkg::COST_W-1:0]  best_mem [NODES];
  logic [rwsp_pkg::NODE_W-1:0]  pred_mem [NODES];
  logic [rwsp_pkg::NODE_W-1:0]  path_mem [NODES];

  logic [CB-1:0]                nx_rd_q, ny_rd_q;
  logic [rwsp_pkg::OCC_W-1:0]   no_rd_q;
  logic [rwsp_pkg::ROW_W-1:0]   adj_rd_q;
  logic [rwsp_pkg::COST_W-1:0]  best_rd_q;
  logic [rwsp_pkg::NODE_W-1:0]  pred_rd_q, path_rd_q;

  logic [IW-1:0]                node_raddr, adj_raddr, best_raddr, best_waddr, path_waddr;
  logic                         best_we, path_we;
  logic [rwsp_pkg::COST_W-1:0]  best_wdata;
  logic [rwsp_pkg::NODE_W-1:0]  path_wdata;

  // Datapath.
  logic [CB-1:0]                dx, dy;
  logic [rwsp_pkg::MA_W-1:0]    mult_a;
  logic [rwsp_pkg::MB_W-1:0]    mult_b;
  logic [rwsp_pkg::MP_W-1:0]    mult_p;
  logic [rwsp_pkg::BCNT_W:0]    rem_sh;
  logic                         div_ge;
  logic [rwsp_pkg::COST_W:0]    cost_sum;
  logic [rwsp_pkg::COST_W-1:0]  nc;
  logic [rwsp_pkg::LEN_W:0]     len_sum;
  logic                         add_t, add_j, sel_take, rel_take, rel_go, bad_ends;
  logic                         sq_start, sq_busy;
  logic [VW-1:0]                sq_op;
  logic [HW-1:0]                sq_root;
  logic [2*CB:0]                dsum;

  assign dx = (ax_q > bx_q) ? (ax_q - bx_q) : (bx_q - ax_q);
  assign dy = (ay_q > by_q) ? (ay_q - by_q) : (by_q - ay_q);

  always_comb begin
    mult_a = rwsp_pkg::MA_W'(dx);
    mult_b = rwsp_pkg::MB_W'(dx);
    case (state_q)
      S_MUL: begin
        mult_a = risk_q;
        mult_b = rwsp_pkg::MB_W'(rw_q);
      end
      S_DY: begin
        mult_a = rwsp_pkg::MA_W'(dy);
        mult_b = rwsp_pkg::MB_W'(dy);
      end
      default: ;
    endcase
  end

  assign mult_p   = rwsp_pkg::MP_W'(mult_a) * rwsp_pkg::MP_W'(mult_b);
  assign rem_sh   = {rem_q, quo_q[rwsp_pkg::DIV_W-1]};
  assign div_ge   = (rem_sh >= {1'b0, b_q});
  assign cost_sum = {1'b0, tcost_q} + (rwsp_pkg::COST_W+1)'(quo_q)
                  + (rwsp_pkg::COST_W+1)'(hop_q);
  assign nc       = cost_sum[rwsp_pkg::COST_W] ? rwsp_pkg::COST_MAX
                                               : cost_sum[rwsp_pkg::COST_W-1:0];
  assign len_sum  = (rwsp_pkg::LEN_W+1)'(len_q) + (rwsp_pkg::LEN_W+1)'(sq_root);
  assign dsum     = (2*CB+1)'(dxx_q) + (2*CB+1)'(dyy_q);
  assign sq_op    = VW'({dsum, 16'h0000});
  assign sq_start = (state_q == S_SQ_GO);

  assign add_t    = row_t_q[k_q[5:0]] && (k_q[5:0] != j_q[5:0]);
  assign add_j    = row_j_q[k_q[5:0]] && (k_q[5:0] != t_q);
  assign sel_take = !settled_q[k_q[IW-1:0]] && reached_q[k_q[IW-1:0]]
                 && (!found_q || (best_rd_q < tcost_q));
  assign rel_go   = (j_q[5:0] != t_q) && row_t_q[j_q[5:0]] && !settled_q[j_q[IW-1:0]];
  assign rel_take = !reached_q[j_q[IW-1:0]] || (nc < best_rd_q);
  assign bad_ends = ({1'b0, s_q} >= n_q) || ({1'b0, g_q} >= n_q);

  rwsp_isqrt #(.VW(VW), .HW(HW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .op_i    (sq_op),
    .busy_o  (sq_busy),
    .root_o  (sq_root)
  );

  // Memory addressing.
  always_comb begin
    node_raddr = '0;
    adj_raddr  = '0;
    best_raddr = '0;
    case (state_q)
      S_ROWT_RD: begin
        node_raddr = t_q[IW-1:0];
        adj_raddr  = t_q[IW-1:0];
      end
      S_REL_RD: begin
        node_raddr = j_q[IW-1:0];
        adj_raddr  = j_q[IW-1:0];
      end
      S_RISK_RD: node_raddr = k_q[IW-1:0];
      S_WALK_RD: node_raddr = y_q[IW-1:0];
      S_WALK_LD: node_raddr = pred_rd_q[IW-1:0];
      S_SEL_RD:  best_raddr = k_q[IW-1:0];
      S_REL_BRD: best_raddr = j_q[IW-1:0];
      default: ;
    endcase
  end

  always_comb begin
    best_we    = 1'b0;
    best_waddr = j_q[IW-1:0];
    best_wdata = nc;
    path_we    = 1'b0;
    path_waddr = cnt_q[IW-1:0];
    path_wdata = p_q;
    case (state_q)
      S_INIT: begin
        best_we    = !bad_ends && (s_q != g_q);
        best_waddr = s_q[IW-1:0];
        best_wdata = '0;
      end
      S_REL_UPD: best_we = rel_take;
      S_SEL_END: begin
        path_we    = found_q && (t_q == g_q);
        path_waddr = '0;
        path_wdata = g_q;
      end
      S_SQ: path_we = !sq_busy && walk_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (s_tuser_i == rwsp_pkg::REQ_NODE) && idx_ok) begin
      nx_mem[in_idx[IW-1:0]] <= in_x16[CB-1:0];
      ny_mem[in_idx[IW-1:0]] <= in_y16[CB-1:0];
      no_mem[in_idx[IW-1:0]] <= in_occ;
    end
    if (in_acc && (s_tuser_i == rwsp_pkg::REQ_ROW) && idx_ok) begin
      adj_mem[in_idx[IW-1:0]] <= in_row;
    end
    if (best_we) begin
      best_mem[best_waddr] <= best_wdata;
      pred_mem[best_waddr] <= t_q;
    end
    if (path_we) begin
      path_mem[path_waddr] <= path_wdata;
    end
    nx_rd_q   <= nx_mem[node_raddr];
    ny_rd_q   <= ny_mem[node_raddr];
    no_rd_q   <= no_mem[node_raddr];
    adj_rd_q  <= adj_mem[adj_raddr];
    best_rd_q <= best_mem[best_raddr];
    pred_rd_q <= pred_mem[y_q[IW-1:0]];
    path_rd_q <= path_mem[i_q[IW-1:0]];
  end

  // Output register.
  logic                        o_valid_q, o_last_q;
  logic [rwsp_pkg::NODE_W-1:0] o_node_q, o_next_q;
  logic [1:0]                  o_status_q;
  logic [rwsp_pkg::COST_W-1:0] o_cost_q;
  logic [rwsp_pkg::LEN_W-1:0]  o_len_q;
  logic                        em_last;

  assign o_free  = !o_valid_q || m_tready_i;
  assign o_load  = o_free && ((state_q == S_SINGLE) || (state_q == S_EM_OUT));
  assign em_last = (rwsp_pkg::CNT_W'(i_q + 7'd1) == cnt_q);

  assign m_tvalid_o = o_valid_q;
  assign m_tdata_o  = {3'b000, o_len_q, o_cost_q, o_next_q, o_node_q};
  assign m_tuser_o  = o_status_q;
  assign m_tlast_o  = o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_load) begin
      o_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_load) begin
      if (state_q == S_SINGLE) begin
        o_node_q   <= r_node_q;
        o_last_q   <= 1'b1;
        o_status_q <= r_status_q;
      end else begin
        o_node_q   <= path_rd_q;
        o_last_q   <= em_last;
        o_status_q <= rwsp_pkg::ST_FOUND;
      end
      o_next_q <= next_q;
      o_cost_q <= tcost_q;
      o_len_q  <= len_q;
    end
  end

  // Sequencer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      k_q       <= '0;
      j_q       <= '0;
      i_q       <= '0;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      walk_q    <= 1'b0;
      settled_q <= '0;
      reached_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && (s_tuser_i == rwsp_pkg::REQ_PLAN)) state_q <= S_INIT;
        end
        S_INIT: begin
          settled_q <= '0;
          k_q       <= '0;
          found_q   <= 1'b0;
          if (bad_ends || (s_q == g_q)) begin
            reached_q <= '0;
            state_q   <= S_SINGLE;
          end else begin
            reached_q <= NODES'(1) << s_q[IW-1:0];
            state_q   <= S_SEL_RD;
          end
        end
        S_SINGLE: begin
          if (o_free) state_q <= S_IDLE;
        end
        S_SEL_RD: state_q <= (k_q == n_q) ? S_SEL_END : S_SEL_CMP;
        S_SEL_CMP: begin
          if (sel_take) found_q <= 1'b1;
          k_q     <= k_q + 7'd1;
          state_q <= S_SEL_RD;
        end
        S_SEL_END: begin
          if (!found_q) begin
            state_q <= S_SINGLE;
          end else if (t_q == g_q) begin
            cnt_q   <= 7'd1;
            walk_q  <= 1'b1;
            state_q <= S_WALK_CHK;
          end else begin
            walk_q  <= 1'b0;
            state_q <= S_ROWT_RD;
          end
        end
        S_ROWT_RD: state_q <= S_ROWT_LD;
        S_ROWT_LD: begin
          j_q     <= '0;
          state_q <= S_REL_CHK;
        end
        S_REL_CHK: begin
          if (j_q == n_q) begin
            settled_q[t_q[IW-1:0]] <= 1'b1;
            k_q     <= '0;
            found_q <= 1'b0;
            state_q <= S_SEL_RD;
          end else if (rel_go) begin
            state_q <= S_REL_RD;
          end else begin
            j_q <= j_q + 7'd1;
          end
        end
        S_REL_RD: state_q <= S_REL_LD;
        S_REL_LD: begin
          k_q     <= '0;
          state_q <= S_RISK_RD;
        end
        S_RISK_RD: state_q <= (k_q == n_q) ? S_MUL : S_RISK_ACC;
        S_RISK_ACC: begin
          k_q     <= k_q + 7'd1;
          state_q <= S_RISK_RD;
        end
        S_MUL: state_q <= S_DIV;
        S_DIV: begin
          if (dcnt_q == 5'd1) state_q <= S_DX;
        end
        S_DX:    state_q <= S_DY;
        S_DY:    state_q <= S_SQ_GO;
        S_SQ_GO: state_q <= S_SQ;
        S_SQ: begin
          if (!sq_busy) begin
            if (walk_q) begin
              cnt_q   <= cnt_q + 7'd1;
              state_q <= S_WALK_CHK;
            end else begin
              state_q <= S_REL_BRD;
            end
          end
        end
        S_REL_BRD: state_q <= S_REL_UPD;
        S_REL_UPD: begin
          if (rel_take) reached_q[j_q[IW-1:0]] <= 1'b1;
          j_q     <= j_q + 7'd1;
          state_q <= S_REL_CHK;
        end
        S_WALK_CHK: begin
          if ((y_q != s_q) && (cnt_q < n_q)) begin
            state_q <= S_WALK_RD;
          end else begin
            i_q     <= '0;
            state_q <= S_EM_RD;
          end
        end
        S_WALK_RD:  state_q <= S_WALK_LD;
        S_WALK_LD:  state_q <= S_WALK_LD2;
        S_WALK_LD2: state_q <= S_DX;
        S_EM_RD:    state_q <= S_EM_OUT;
        S_EM_OUT: begin
          if (o_free) begin
            if (em_last) begin
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q + 7'd1;
              state_q <= S_EM_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        s_q <= in_start;
        g_q <= in_goal;
        n_q <= in_cnt_lim;
      end
      S_INIT: begin
        len_q <= '0;
        if (bad_ends) begin
          r_node_q   <= g_q;
          r_status_q <= rwsp_pkg::ST_UNREACH;
          next_q     <= '0;
          tcost_q    <= rwsp_pkg::COST_MAX;
        end else begin
          r_node_q   <= s_q;
          r_status_q <= rwsp_pkg::ST_SAME;
          next_q     <= s_q;
          tcost_q    <= '0;
        end
      end
      S_SEL_CMP: begin
        if (sel_take) begin
          t_q     <= k_q[5:0];
          tcost_q <= best_rd_q;
        end
      end
      S_SEL_END: begin
        len_q <= '0;
        y_q   <= g_q;
        if (!found_q) begin
          r_node_q   <= g_q;
          r_status_q <= rwsp_pkg::ST_UNREACH;
          next_q     <= '0;
          tcost_q    <= rwsp_pkg::COST_MAX;
        end
      end
      S_ROWT_LD: begin
        row_t_q <= adj_rd_q;
        ax_q    <= nx_rd_q;
        ay_q    <= ny_rd_q;
        occ_t_q <= no_rd_q;
      end
      S_REL_LD: begin
        row_j_q <= adj_rd_q;
        bx_q    <= nx_rd_q;
        by_q    <= ny_rd_q;
        risk_q  <= rwsp_pkg::RISK_W'(occ_t_q) + rwsp_pkg::RISK_W'(no_rd_q);
        b_q     <= 8'd2;
      end
      S_RISK_ACC: begin
        risk_q <= risk_q + (add_t ? rwsp_pkg::RISK_W'(no_rd_q) : '0)
                         + (add_j ? rwsp_pkg::RISK_W'(no_rd_q) : '0);
        b_q    <= b_q + rwsp_pkg::BCNT_W'(add_t) + rwsp_pkg::BCNT_W'(add_j);
      end
      S_MUL: begin
        quo_q  <= mult_p[29:8];
        rem_q  <= '0;
        dcnt_q <= 5'(rwsp_pkg::DIV_W);
      end
      S_DIV: begin
        rem_q  <= div_ge ? rwsp_pkg::BCNT_W'(rem_sh - {1'b0, b_q})
                         : rem_sh[rwsp_pkg::BCNT_W-1:0];
        quo_q  <= {quo_q[rwsp_pkg::DIV_W-2:0], div_ge};
        dcnt_q <= dcnt_q - 5'd1;
      end
      S_DX: dxx_q <= mult_p[2*CB-1:0];
      S_DY: dyy_q <= mult_p[2*CB-1:0];
      S_SQ: begin
        if (!sq_busy) begin
          if (walk_q) begin
            len_q  <= len_sum[rwsp_pkg::LEN_W] ? rwsp_pkg::LEN_MAX
                                               : len_sum[rwsp_pkg::LEN_W-1:0];
            next_q <= y_q;
            y_q    <= p_q;
          end else begin
            hop_q <= sq_root;
          end
        end
      end
      S_WALK_LD: begin
        p_q  <= pred_rd_q;
        ax_q <= nx_rd_q;
        ay_q <= ny_rd_q;
      end
      S_WALK_LD2: begin
        bx_q <= nx_rd_q;
        by_q <= ny_rd_q;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_idle_root_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o |-> !sq_busy)
    else $error("square root unit busy while the planner is idle");

  a_settled_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (settled_q & ~reached_q) == '0)
    else $error("settled node that was never reached");

  a_sel_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEL_CMP) |-> ($past(state_q) == S_SEL_RD))
    else $error("cost compare without a preceding read");

  a_root_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |=> sq_busy)
    else $error("square root did not start");
`endif

endmodule
